[rtl/core/sfe_pkg.sv]
// Shared types, constants and helper functions of the spectrum feature extractor.
package sfe_pkg;

  localparam int DEF_FFT_POINTS = 512;
  localparam int DEF_MAX_BANDS  = 8;

  localparam logic [1:0] KIND_BIN     = 2'd0;
  localparam logic [1:0] KIND_BAND    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] REG_SMOOTHING  = 3'd0;
  localparam logic [2:0] REG_VOICE_THR  = 3'd1;
  localparam logic [2:0] REG_VOICE_LOW  = 3'd2;
  localparam logic [2:0] REG_VOICE_HIGH = 3'd3;
  localparam logic [2:0] REG_BIN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_BAND_COUNT = 3'd5;
  localparam logic [2:0] REG_BAND_LOW   = 3'd6;
  localparam logic [2:0] REG_BAND_HIGH  = 3'd7;

  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [18:0] DB_K    = 19'd394565;
  localparam logic signed [15:0] DB_FLOOR = -16'sd25600;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_RE,
    OP_SQ_IM,
    OP_SQRT_STEP,
    OP_SMOOTH1,
    OP_SMOOTH2,
    OP_ACCUM,
    OP_WACC,
    OP_EMIT_BIN,
    OP_BAND_SETUP,
    OP_BAND_AVG,
    OP_LOG_STEP,
    OP_DB1,
    OP_DB2,
    OP_EMIT_BAND,
    OP_VP_START,
    OP_VP_DONE,
    OP_CEN_START,
    OP_CEN_DONE,
    OP_EMIT_SUM
  } sfe_op_t;

  typedef struct packed {
    sfe_op_t    op;
    logic [3:0] band;
    logic [3:0] step;
  } sfe_cmd_t;

  typedef struct packed {
    logic       frame_end;
    logic       div_done;
    logic [3:0] band_num;
  } sfe_status_t;

  function automatic logic [7:0] clamp_bin(input logic [7:0] v, input logic [7:0] last);
    return (v > last) ? last : v;
  endfunction

  function automatic logic [4:0] lead_one(input logic [23:0] v);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage

[rtl/core/spectrum_feature_extractor_core.sv]
// Top level of the spectrum feature extractor: register port, controller and datapath.
// One bin is processed at a time; the next is taken only when the controller is idle.
// Bin time is set mostly by the 32-step square root unit.
// On the frame-end bin each band adds a divider pass and 16 log steps,
// and the summary two passes of the shared divider; output stalls add time.
// Reset (rst_n low, synchronous) restores register defaults and clears all sums;
// previous magnitudes read as zero through per-entry valid bits, with no clearing pass.
module spectrum_feature_extractor_core
  import sfe_pkg::*;
#(
  parameter int FFT_POINTS = DEF_FFT_POINTS,
  parameter int MAX_BANDS  = DEF_MAX_BANDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_bin_real,
  input  logic signed [31:0] in_bin_imag,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_item_index,
  output logic [23:0]        out_level,
  output logic signed [15:0] out_level_db,
  output logic [16:0]        out_voice_prob,
  output logic               out_voice_flag,
  output logic [15:0]        out_centroid_hz,
  output logic [15:0]        out_dominant_hz,
  output logic               out_run_last
);

  // Configuration registers sit at 8-byte strides since the band tables are 64 bits.
  logic [16:0] smoothing_r;
  logic [16:0] voice_thr_r;
  logic [7:0]  voice_low_r;
  logic [7:0]  voice_high_r;
  logic [15:0] bin_width_r;
  logic [3:0]  band_count_r;
  logic [63:0] band_low_r;
  logic [63:0] band_high_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  sfe_cmd_t    cmd;
  sfe_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_r  <= 17'd65536;
      voice_thr_r  <= 17'd32768;
      voice_low_r  <= 8'd0;
      voice_high_r <= 8'd255;
      bin_width_r  <= 16'd24000;
      band_count_r <= 4'd7;
      band_low_r   <= '0;
      band_high_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SMOOTHING:  smoothing_r  <= pwdata[16:0];
        REG_VOICE_THR:  voice_thr_r  <= pwdata[16:0];
        REG_VOICE_LOW:  voice_low_r  <= pwdata[7:0];
        REG_VOICE_HIGH: voice_high_r <= pwdata[7:0];
        REG_BIN_WIDTH:  bin_width_r  <= pwdata[15:0];
        REG_BAND_COUNT: band_count_r <= pwdata[3:0];
        REG_BAND_LOW:   band_low_r   <= pwdata;
        REG_BAND_HIGH:  band_high_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SMOOTHING:  prdata = {47'd0, smoothing_r};
      REG_VOICE_THR:  prdata = {47'd0, voice_thr_r};
      REG_VOICE_LOW:  prdata = {56'd0, voice_low_r};
      REG_VOICE_HIGH: prdata = {56'd0, voice_high_r};
      REG_BIN_WIDTH:  prdata = {48'd0, bin_width_r};
      REG_BAND_COUNT: prdata = {60'd0, band_count_r};
      REG_BAND_LOW:   prdata = band_low_r;
      REG_BAND_HIGH:  prdata = band_high_r;
      default:        prdata = '0;
    endcase
  end

  // The controller sequences one transaction at a time; results wait in the
  // datapath's output register so the next bin can be taken meanwhile.
  sfe_ctrl #(
    .MAX_BANDS (MAX_BANDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfe_dp #(
    .FFT_POINTS (FFT_POINTS),
    .MAX_BANDS  (MAX_BANDS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_bin_real         (in_bin_real),
    .in_bin_imag         (in_bin_imag),
    .in_frame_end        (in_frame_end),
    .cfg_smoothing       (smoothing_r),
    .cfg_voice_threshold (voice_thr_r),
    .cfg_voice_low_bin   (voice_low_r),
    .cfg_voice_high_bin  (voice_high_r),
    .cfg_bin_width_hz    (bin_width_r),
    .cfg_band_count      (band_count_r),
    .cfg_band_low_bins   (band_low_r),
    .cfg_band_high_bins  (band_high_r),
    .out_kind            (out_kind),
    .out_item_index      (out_item_index),
    .out_level           (out_level),
    .out_level_db        (out_level_db),
    .out_voice_prob      (out_voice_prob),
    .out_voice_flag      (out_voice_flag),
    .out_centroid_hz     (out_centroid_hz),
    .out_dominant_hz     (out_dominant_hz),
    .out_run_last        (out_run_last)
  );

endmodule

[rtl/core/sfe_div.sv]
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module sfe_div
  import sfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic [47:0] quotient,
  output logic        done
);

  logic [47:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r, q_r[47]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 32'(rem_sh - {1'b0, dvs_r});
        q_r   <= {q_r[46:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

[rtl/core/sfe_dp.sv]
// Datapath: magnitude, smoothing, frame sums, band averages, dB and summary arithmetic.
module sfe_dp
  import sfe_pkg::*;
#(
  parameter int FFT_POINTS = DEF_FFT_POINTS,
  parameter int MAX_BANDS  = DEF_MAX_BANDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfe_cmd_t           cmd,
  output sfe_status_t        status,
  input  logic signed [31:0] in_bin_real,
  input  logic signed [31:0] in_bin_imag,
  input  logic               in_frame_end,
  input  logic [16:0]        cfg_smoothing,
  input  logic [16:0]        cfg_voice_threshold,
  input  logic [7:0]         cfg_voice_low_bin,
  input  logic [7:0]         cfg_voice_high_bin,
  input  logic [15:0]        cfg_bin_width_hz,
  input  logic [3:0]         cfg_band_count,
  input  logic [63:0]        cfg_band_low_bins,
  input  logic [63:0]        cfg_band_high_bins,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_item_index,
  output logic [23:0]        out_level,
  output logic signed [15:0] out_level_db,
  output logic [16:0]        out_voice_prob,
  output logic               out_voice_flag,
  output logic [15:0]        out_centroid_hz,
  output logic [15:0]        out_dominant_hz,
  output logic               out_run_last
);

  localparam int LOG2N = $clog2(FFT_POINTS);
  localparam int LAST_BIN_I = (FFT_POINTS / 2 - 1 > 255) ? 255 : FFT_POINTS / 2 - 1;
  localparam logic [7:0] LAST_BIN = 8'(LAST_BIN_I);
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

  logic [31:0] re_r, im_r;
  logic        fe_r;
  logic [63:0] prod_r, rad_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [23:0] prev_raw_r;
  logic        prev_ok_r;
  logic [40:0] smp_r;
  logic [23:0] sm_r;
  logic [31:0] wprod_r;
  logic [7:0]  bin_r;
  logic [23:0] mem [256];
  logic [255:0] valid_r;
  logic [31:0] band_sum_r [MAX_BANDS];
  logic [31:0] total_r, voice_r;
  logic [39:0] weighted_r;
  logic [23:0] peak_val_r;
  logic [7:0]  peak_bin_r;
  logic        empty_r;
  logic [23:0] avg_r;
  logic [31:0] m_r;
  logic [20:0] l2_r;
  logic [39:0] dbprod_r;
  logic signed [15:0] db_r;
  logic [16:0] vp_r;
  logic        isv_r;
  logic [55:0] cenprod_r;
  logic [15:0] cen_r;

  logic [31:0] re_u, im_u, re_abs, im_abs;
  logic [33:0] rem_sh, trial;
  logic [31:0] mag_full;
  logic [23:0] mag24;
  logic [16:0] s_eff, inv_s, thr_eff;
  logic [41:0] sm_acc;
  logic [23:0] prev;
  logic [BAND_W-1:0] bsel;
  logic [7:0]  cur_lo, cur_hi;
  logic [8:0]  cur_cnt;
  logic [7:0]  vlo, vhi;
  logic        div_start, div_done;
  logic [47:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic [23:0] avg_new;
  logic [4:0]  lead_e;
  logic [63:0] sq;
  logic [31:0] mm;
  logic [20:0] db_neg;
  logic [40:0] db_rnd;
  logic [16:0] db_mag;
  logic [16:0] vp_new;
  logic [23:0] dom_prod;
  logic [39:0] wsum;
  logic [3:0]  nb;

  assign re_u   = in_bin_real;
  assign im_u   = in_bin_imag;
  assign re_abs = re_u[31] ? (~re_u + 32'd1) : re_u;
  assign im_abs = im_u[31] ? (~im_u + 32'd1) : im_u;

  assign rem_sh = {rem_r[31:0], rad_r[63:62]};
  assign trial  = {root_r, 2'b01};

  assign mag_full = root_r >> LOG2N;
  assign mag24    = (|mag_full[31:24]) ? 24'hFFFFFF : mag_full[23:0];
  assign s_eff    = (cfg_smoothing > Q16_ONE) ? Q16_ONE : cfg_smoothing;
  assign inv_s    = Q16_ONE - s_eff;
  assign thr_eff  = (cfg_voice_threshold > Q16_ONE) ? Q16_ONE : cfg_voice_threshold;
  assign prev     = prev_ok_r ? prev_raw_r : 24'd0;
  assign sm_acc   = {1'b0, smp_r} + inv_s * prev + 42'd32768;

  assign bsel    = cmd.band[BAND_W-1:0];
  assign cur_lo  = clamp_bin(cfg_band_low_bins[8*cmd.band[2:0] +: 8], LAST_BIN);
  assign cur_hi  = clamp_bin(cfg_band_high_bins[8*cmd.band[2:0] +: 8], LAST_BIN);
  assign cur_cnt = {1'b0, cur_hi} - {1'b0, cur_lo} + 9'd1;
  assign vlo     = clamp_bin(cfg_voice_low_bin, LAST_BIN);
  assign vhi     = clamp_bin(cfg_voice_high_bin, LAST_BIN);

  assign avg_new = empty_r ? 24'd0 : ((|div_q[47:24]) ? 24'hFFFFFF : div_q[23:0]);
  assign lead_e  = lead_one(avg_new);
  assign sq      = m_r * m_r;
  assign mm      = sq[61:30];
  assign db_neg  = 21'd1572864 - l2_r;
  assign db_rnd  = {1'b0, dbprod_r} + 41'd8388608;
  assign db_mag  = db_rnd[40:24];
  assign vp_new  = (total_r == 32'd0) ? 17'd0 :
                   ((div_q > 48'd65536) ? Q16_ONE : div_q[16:0]);
  assign dom_prod = peak_bin_r * cfg_bin_width_hz;
  assign wsum     = ({8'd0, wprod_r} + weighted_r < weighted_r) ? '1
                    : {8'd0, wprod_r} + weighted_r;
  assign nb       = (cfg_band_count > 4'(MAX_BANDS)) ? 4'(MAX_BANDS) : cfg_band_count;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = (total_r == 32'd0) ? 32'd1 : total_r;
    unique case (cmd.op)
      OP_BAND_SETUP: begin
        div_start = 1'b1;
        div_dvd   = {16'd0, band_sum_r[bsel]};
        div_dvs   = (cur_hi < cur_lo) ? 32'd1 : {23'd0, cur_cnt};
      end
      OP_VP_START: begin
        div_start = 1'b1;
        div_dvd   = {voice_r, 16'd0};
      end
      OP_CEN_START: begin
        div_start = 1'b1;
        div_dvd   = cenprod_r[55:8];
      end
      default: ;
    endcase
  end

  sfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // Previous-frame store: valid bits make unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCUM) mem[bin_r] <= sm_r;
    if (cmd.op == OP_LOAD) prev_raw_r <= mem[bin_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.op == OP_ACCUM) begin
      valid_r[bin_r] <= 1'b1;
    end
  end

  // Per-frame accumulators.
  always_ff @(posedge clk) begin
    logic [32:0] s33;
    if (!rst_n) begin
      for (int b = 0; b < MAX_BANDS; b++) band_sum_r[b] <= '0;
      total_r    <= '0;
      voice_r    <= '0;
      weighted_r <= '0;
      peak_val_r <= '0;
      peak_bin_r <= '0;
      bin_r      <= '0;
    end else begin
      unique case (cmd.op)
        OP_ACCUM: begin
          for (int b = 0; b < MAX_BANDS; b++) begin
            if (bin_r >= clamp_bin(cfg_band_low_bins[8*b +: 8], LAST_BIN) &&
                bin_r <= clamp_bin(cfg_band_high_bins[8*b +: 8], LAST_BIN)) begin
              s33 = {1'b0, band_sum_r[b]} + {9'd0, sm_r};
              band_sum_r[b] <= s33[32] ? 32'hFFFFFFFF : s33[31:0];
            end
          end
          if (bin_r >= vlo && bin_r <= vhi) begin
            s33 = {1'b0, voice_r} + {9'd0, sm_r};
            voice_r <= s33[32] ? 32'hFFFFFFFF : s33[31:0];
          end
          s33 = {1'b0, total_r} + {9'd0, sm_r};
          total_r <= s33[32] ? 32'hFFFFFFFF : s33[31:0];
          if (sm_r > peak_val_r) begin
            peak_val_r <= sm_r;
            peak_bin_r <= bin_r;
          end
        end
        OP_WACC: weighted_r <= wsum;
        OP_EMIT_BIN: begin
          if (!fe_r) bin_r <= bin_r + 8'd1;
        end
        OP_EMIT_SUM: begin
          for (int b = 0; b < MAX_BANDS; b++) band_sum_r[b] <= '0;
          total_r    <= '0;
          voice_r    <= '0;
          weighted_r <= '0;
          peak_val_r <= '0;
          peak_bin_r <= '0;
          bin_r      <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        re_r      <= re_abs;
        im_r      <= im_abs;
        fe_r      <= in_frame_end;
        prev_ok_r <= valid_r[bin_r];
      end
      OP_SQ_RE: prod_r <= re_r * re_r;
      OP_SQ_IM: begin
        rad_r  <= prod_r + im_r * im_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQRT_STEP: begin
        rad_r <= {rad_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= 33'(rem_sh - trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[32:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      OP_SMOOTH1: smp_r <= s_eff * mag24;
      OP_SMOOTH2: sm_r <= sm_acc[39:16];
      OP_ACCUM:   wprod_r <= bin_r * sm_r;
      OP_EMIT_BIN: begin
        out_kind        <= KIND_BIN;
        out_item_index  <= bin_r;
        out_level       <= sm_r;
        out_level_db    <= '0;
        out_voice_prob  <= '0;
        out_voice_flag  <= 1'b0;
        out_centroid_hz <= '0;
        out_dominant_hz <= '0;
        out_run_last    <= !fe_r;
      end
      OP_BAND_SETUP: empty_r <= cur_hi < cur_lo;
      OP_BAND_AVG: begin
        avg_r <= avg_new;
        m_r   <= 32'(avg_new) << (5'd30 - lead_e);
        l2_r  <= {lead_e, 16'd0};
      end
      OP_LOG_STEP: begin
        if (mm[31]) begin
          m_r  <= mm >> 1;
          l2_r <= l2_r | (21'd1 << (4'd15 - cmd.step));
        end else begin
          m_r <= mm;
        end
      end
      OP_DB1: dbprod_r <= db_neg * DB_K;
      OP_DB2: begin
        db_r <= (avg_r == 24'd0 || db_mag > 17'd25600) ? DB_FLOOR
                : $signed(16'(17'd0 - db_mag));
      end
      OP_EMIT_BAND: begin
        out_kind        <= KIND_BAND;
        out_item_index  <= {4'd0, cmd.band};
        out_level       <= avg_r;
        out_level_db    <= db_r;
        out_voice_prob  <= '0;
        out_voice_flag  <= 1'b0;
        out_centroid_hz <= '0;
        out_dominant_hz <= '0;
        out_run_last    <= 1'b0;
      end
      OP_VP_DONE: begin
        vp_r      <= vp_new;
        isv_r     <= vp_new > thr_eff;
        cenprod_r <= weighted_r * cfg_bin_width_hz;
      end
      OP_CEN_DONE: begin
        cen_r <= (total_r == 32'd0) ? 16'd0 :
                 ((|div_q[47:16]) ? 16'hFFFF : div_q[15:0]);
      end
      OP_EMIT_SUM: begin
        out_kind        <= KIND_SUMMARY;
        out_item_index  <= '0;
        out_level       <= '0;
        out_level_db    <= '0;
        out_voice_prob  <= vp_r;
        out_voice_flag  <= isv_r;
        out_centroid_hz <= cen_r;
        out_dominant_hz <= dom_prod[23:8];
        out_run_last    <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status.frame_end = fe_r;
  assign status.div_done  = div_done;
  assign status.band_num  = nb;

endmodule

[rtl/core/sfe_ctrl.sv]
// Controller state machine sequencing the datapath for bins, bands and the summary.
module sfe_ctrl
  import sfe_pkg::*;
#(
  parameter int MAX_BANDS = DEF_MAX_BANDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  sfe_status_t status,
  output sfe_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_RE, ST_SQ_IM, ST_SQRT, ST_SM1, ST_SM2, ST_ACC, ST_WACC,
    ST_EMIT_BIN, ST_BAND_NEXT, ST_BAND_WAIT, ST_BAND_AVG, ST_LOG, ST_DB1, ST_DB2,
    ST_EMIT_BAND, ST_VP_START, ST_VP_WAIT, ST_VP_DONE, ST_CEN_START, ST_CEN_WAIT,
    ST_CEN_DONE, ST_EMIT_SUM
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [3:0] band_r, band_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load, load;

  assign can_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    band_nxt  = band_r;
    load      = 1'b0;
    cmd.op    = OP_NONE;
    cmd.band  = band_r;
    cmd.step  = cnt_r[3:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SQ_RE;
        end
      end
      ST_SQ_RE: begin
        cmd.op    = OP_SQ_RE;
        state_nxt = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        cmd.op    = OP_SQ_IM;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_SM1;
      end
      ST_SM1: begin
        cmd.op    = OP_SMOOTH1;
        state_nxt = ST_SM2;
      end
      ST_SM2: begin
        cmd.op    = OP_SMOOTH2;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACCUM;
        state_nxt = ST_WACC;
      end
      ST_WACC: begin
        cmd.op    = OP_WACC;
        state_nxt = ST_EMIT_BIN;
      end
      ST_EMIT_BIN: begin
        if (can_load) begin
          cmd.op    = OP_EMIT_BIN;
          load      = 1'b1;
          band_nxt  = '0;
          state_nxt = status.frame_end ? ST_BAND_NEXT : ST_IDLE;
        end
      end
      ST_BAND_NEXT: begin
        if (band_r >= status.band_num) begin
          state_nxt = ST_VP_START;
        end else begin
          cmd.op    = OP_BAND_SETUP;
          state_nxt = ST_BAND_WAIT;
        end
      end
      ST_BAND_WAIT: begin
        if (status.div_done) state_nxt = ST_BAND_AVG;
      end
      ST_BAND_AVG: begin
        cmd.op    = OP_BAND_AVG;
        cnt_nxt   = '0;
        state_nxt = ST_LOG;
      end
      ST_LOG: begin
        cmd.op  = OP_LOG_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) state_nxt = ST_DB1;
      end
      ST_DB1: begin
        cmd.op    = OP_DB1;
        state_nxt = ST_DB2;
      end
      ST_DB2: begin
        cmd.op    = OP_DB2;
        state_nxt = ST_EMIT_BAND;
      end
      ST_EMIT_BAND: begin
        if (can_load) begin
          cmd.op    = OP_EMIT_BAND;
          load      = 1'b1;
          band_nxt  = band_r + 4'd1;
          state_nxt = ST_BAND_NEXT;
        end
      end
      ST_VP_START: begin
        cmd.op    = OP_VP_START;
        state_nxt = ST_VP_WAIT;
      end
      ST_VP_WAIT: begin
        if (status.div_done) state_nxt = ST_VP_DONE;
      end
      ST_VP_DONE: begin
        cmd.op    = OP_VP_DONE;
        state_nxt = ST_CEN_START;
      end
      ST_CEN_START: begin
        cmd.op    = OP_CEN_START;
        state_nxt = ST_CEN_WAIT;
      end
      ST_CEN_WAIT: begin
        if (status.div_done) state_nxt = ST_CEN_DONE;
      end
      ST_CEN_DONE: begin
        cmd.op    = OP_CEN_DONE;
        state_nxt = ST_EMIT_SUM;
      end
      ST_EMIT_SUM: begin
        if (can_load) begin
          cmd.op    = OP_EMIT_SUM;
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      band_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      band_r      <= band_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");
  a_band_bound: assert property (@(posedge clk) disable iff (!rst_n)
    band_r <= 4'(MAX_BANDS))
    else $error("band index ran past the band limit");
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && cnt_r == 5'd31) |=> (state_r == ST_SM1))
    else $error("square root did not finish after 32 steps");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(state_r == ST_IDLE) ||
                                     out_valid_r))
    else $error("pending result dropped");
`endif

endmodule
